@@ sv/imtf_pkg.sv @@
// ----------------------------------------------------------------------------
// imtf_pkg
// shared widths, defaults and table command type for the inverse mtf decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imtf_pkg;

  localparam int SymW            = 8;    // symbol and index width
  localparam int DefAlphabetSize = 256;  // default recency table depth

  // per-cycle request to the recency table
  typedef struct packed {
    logic rd_en;  // read entry at raddr, data next cycle
    logic wr_en;  // write wdata at waddr
    logic clr;    // table back to identity
  } tbl_cmd_t;

endpackage

`default_nettype wire

@@ sv/imtf_ram.sv @@
// ----------------------------------------------------------------------------
// imtf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/imtf_table.sv @@
// ----------------------------------------------------------------------------
// imtf_table
// recency table: ram plus per-entry valid bits, unwritten entries read as index
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imtf_table #(
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire imtf_pkg::tbl_cmd_t               cmd_i,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0] raddr_i,
  input  wire logic [$clog2(ALPHABET_SIZE)-1:0] waddr_i,
  input  wire logic [imtf_pkg::SymW-1:0]        wdata_i,
  output logic      [imtf_pkg::SymW-1:0]        rdata_o
);
  import imtf_pkg::*;

  localparam int Aw = $clog2(ALPHABET_SIZE);

  logic [ALPHABET_SIZE-1:0] valid_q;
  logic                     rvalid_q;
  logic [Aw-1:0]            raddr_q;
  logic [SymW-1:0]          ram_rdata;

  imtf_ram #(
    .WIDTH (SymW),
    .DEPTH (ALPHABET_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // valid bits: clear returns every entry to its identity value at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      raddr_q <= raddr_i;
    end
  end

  assign rdata_o = rvalid_q ? ram_rdata : SymW'(raddr_q);

endmodule

`default_nettype wire

@@ sv/inverse_move_to_front_top.sv @@
// ----------------------------------------------------------------------------
// inverse_move_to_front_top
// inverse move-to-front decoder over a recency table of alphabet_size bytes
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one move-to-front index and
// returns the byte held at that position of the recency table. A nonzero
// index moves that byte to the front and pushes the entries ahead of it back
// by one; indexes at or above ALPHABET_SIZE saturate to the last entry. The
// table starts as identity and returns to identity after a request with tlast
// set, so every sequence decodes on its own. The table lives in one
// simple dual-port ram driven by a small sequencer that moves one entry per
// cycle through the single read and write port of that ram, so a request
// with effective index p shifts p entries and holds off the next request
// until done. Unwritten entries are covered by per-entry valid bits, so no
// clearing pass is needed after reset or after end of sequence. The finished
// symbol sits in an output register, so the next request is taken while the
// result still waits on the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module inverse_move_to_front_top #(
  parameter int ALPHABET_SIZE = imtf_pkg::DefAlphabetSize
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // slave stream
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [imtf_pkg::SymW-1:0] s_axis_tdata,   // [7:0] mtf_index
  input  wire logic                      s_axis_tlast,   // end_of_sequence
  // master stream
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic      [imtf_pkg::SymW-1:0] m_axis_tdata,   // [7:0] symbol_value
  output logic                           m_axis_tlast    // last_out
);
  import imtf_pkg::*;

  localparam int Aw = $clog2(ALPHABET_SIZE);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a request
    ST_LOOK,   // read the indexed entry
    ST_GRAB,   // capture symbol, start shifting
    ST_SHIFT,  // move entry k-1 to k, one per cycle
    ST_FRONT,  // put symbol at position 0
    ST_DONE    // hand result to output register
  } state_e;

  state_e          state_q;
  logic [Aw-1:0]   pos_q;     // saturated index
  logic [Aw-1:0]   k_q;       // shift destination
  logic            last_q;
  logic [SymW-1:0] value_q;
  logic            out_valid_q;
  logic [SymW-1:0] out_data_q;
  logic            out_last_q;

  logic            s_fire;
  logic            out_free;
  logic [Aw-1:0]   pos_sat;

  tbl_cmd_t        tbl_cmd;
  logic [Aw-1:0]   tbl_raddr;
  logic [Aw-1:0]   tbl_waddr;
  logic [SymW-1:0] tbl_wdata;
  logic [SymW-1:0] tbl_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // indexes beyond the table clamp to the last entry
  assign pos_sat = (int'(s_axis_tdata) >= ALPHABET_SIZE) ? Aw'(ALPHABET_SIZE - 1)
                                                         : s_axis_tdata[Aw-1:0];

  // table requests per sequencer step
  always_comb begin
    tbl_cmd   = '0;
    tbl_raddr = k_q - Aw'(1);
    tbl_waddr = k_q;
    tbl_wdata = tbl_rdata;
    unique case (state_q)
      ST_LOOK: begin
        tbl_cmd.rd_en = 1'b1;
        tbl_raddr     = pos_q;
      end
      ST_GRAB: begin
        // first shift source is pos-1
        tbl_cmd.rd_en = (pos_q != '0);
        tbl_raddr     = pos_q - Aw'(1);
      end
      ST_SHIFT: begin
        // read data is entry k-1; fetch k-2 for the next step
        tbl_cmd.wr_en = 1'b1;
        tbl_cmd.rd_en = (k_q != Aw'(1));
        tbl_raddr     = k_q - Aw'(2);
      end
      ST_FRONT: begin
        tbl_cmd.wr_en = 1'b1;
        tbl_waddr     = '0;
        tbl_wdata     = value_q;
      end
      ST_DONE: begin
        tbl_cmd.clr = out_free && last_q;
      end
      default: begin
      end
    endcase
  end

  imtf_table #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tbl_cmd),
    .raddr_i (tbl_raddr),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
      value_q     <= '0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // new result loads, otherwise a taken result empties the register
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            pos_q   <= pos_sat;
            last_q  <= s_axis_tlast;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          k_q     <= pos_q;
          state_q <= ST_GRAB;
        end
        ST_GRAB: begin
          value_q <= tbl_rdata;
          state_q <= (pos_q != '0) ? ST_SHIFT : ST_DONE;
        end
        ST_SHIFT: begin
          k_q <= k_q - Aw'(1);
          if (k_q == Aw'(1)) begin
            state_q <= ST_FRONT;
          end
        end
        ST_FRONT: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_q  <= value_q;
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // shift loop never runs with destination zero
  a_shift_dest_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (k_q != '0))
    else $error("shift step with destination zero");

  // a request is followed by a busy block
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("request taken while previous one still in work");

  // the shift reads ahead of the write, never at the same entry
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_cmd.wr_en && tbl_cmd.rd_en) |-> (tbl_waddr != tbl_raddr))
    else $error("table read and write at one entry");

  // table is cleared only when a last result is handed over
  a_clear_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd.clr |=> (out_valid_q && out_last_q))
    else $error("table cleared without end of sequence");

endmodule

`default_nettype wire
